>>> hdl/bf3m_pkg.sv
`default_nettype none
package bf3m_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int SUM_W     = 12;

  // floor(x / 9) == (x * 7282) >> 16 for every x below 2304
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             flush;
  } pix_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] mean_value;
    logic             last_of_frame;
  } res_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] two_above;
    logic [PIX_W-1:0] above;
  } line_pair_t;

endpackage
`default_nettype wire

>>> hdl/bf3m_line_mem.sv
`default_nettype none
module bf3m_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                rd_en,
  input  wire logic [AW-1:0]       rd_addr,
  input  wire logic                wr_en,
  input  wire logic [AW-1:0]       wr_addr,
  input  wire bf3m_pkg::line_pair_t wr_data,
  output      bf3m_pkg::line_pair_t rd_data
);
  import bf3m_pkg::*;

  line_pair_t mem [DEPTH];
  line_pair_t mem_q;
  line_pair_t fwd_q;
  logic       fwd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
      fwd_q <= wr_data;
    end
  end

  // same-entry read and write on one edge: pass the new data through
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (rd_en) begin
      fwd <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd ? fwd_q : mem_q;

endmodule
`default_nettype wire

>>> hdl/bf3m_out_fifo.sv
`default_nettype none
module bf3m_out_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  input  wire bf3m_pkg::res_item_t           push_data,
  output      logic                          res_valid,
  input  wire logic                          res_stall,
  output      bf3m_pkg::res_item_t           res_data,
  output      logic [bf3m_pkg::OUT_CNT_W-1:0] level
);
  import bf3m_pkg::*;

  res_item_t             buf_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]  wr_ptr;
  logic [OUT_PTR_W-1:0]  rd_ptr;
  logic [OUT_CNT_W-1:0]  count;
  logic                  pop;

  assign res_valid = (count != '0);
  assign pop       = res_valid && !res_stall;
  assign res_data  = buf_q[rd_ptr];
  assign level     = count;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/box_filter_3x3_mean_unit.sv
// channel | direction | handshake            | payload
// pix     | in        | pix_valid/pix_stall  | pix_item_t (pixel, flush)
// res     | out       | res_valid/res_stall  | res_item_t (mean_value, last_of_frame)
// cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One pixel per clock while pix_stall is low. Each pixel passes the line memory
// read and window sum (s1), then the divide by 9 (s2); results wait in a 4-entry
// output FIFO. Line memory: one read and one write port, same-entry write forwarded.
// Reset (rst, synchronous) clears positions, window and FIFO; line memory is not
// cleared. pix_stall rises when FIFO entries plus in-flight items reach 4.
`default_nettype none
module box_filter_3x3_mean_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            pix_valid,
  output      logic                            pix_stall,
  input  wire bf3m_pkg::pix_item_t             pix_data,
  output      logic                            res_valid,
  input  wire logic                            res_stall,
  output      bf3m_pkg::res_item_t             res_data,
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [bf3m_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bf3m_pkg::CFG_W-1:0]      cfg_data
);
  import bf3m_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int WW = (WB > CFG_W) ? WB : CFG_W;
  localparam int HB = $clog2(MAX_HEIGHT + 4);
  localparam int HX = (HB > CFG_W) ? HB : CFG_W;
  localparam int PROD_W = SUM_W + RECIP_W;

  function automatic logic [9:0] col_sum(input logic [PIX_W-1:0] a,
                                         input logic [PIX_W-1:0] b,
                                         input logic [PIX_W-1:0] c);
    return 10'(a) + 10'(b) + 10'(c);
  endfunction

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic [WW-1:0]    eff_w;
  logic [HX-1:0]    eff_h;
  logic [WW-1:0]    fw_ext;
  logic [HX-1:0]    fh_ext;

  logic             accept;
  logic             cfg_wr;
  logic [CW-1:0]    col;
  logic [HX-1:0]    row;
  logic [CW-1:0]    col_next;
  logic [HX-1:0]    row_next;
  logic [WW-1:0]    col_inc;
  logic             last0;
  logic             emit0;
  logic [2:0]       row_ok;

  logic             s1_valid;
  logic [CW-1:0]    s1_col;
  logic [PIX_W-1:0] s1_pix;
  logic [2:0]       s1_ok;
  logic             s1_czero;
  logic             s1_cge2;
  logic             s1_wge2;
  logic             s1_rzero;
  logic             s1_emit;
  logic             s1_last;

  line_pair_t       rd_pair;
  line_pair_t       wr_pair;
  logic [PIX_W-1:0] newcol [3];
  logic [PIX_W-1:0] win0 [3];
  logic [PIX_W-1:0] win1 [3];
  logic             use_w0;
  logic             use_w1;
  logic [SUM_W-1:0] sum1;

  logic             s2_valid;
  logic [SUM_W-1:0] s2_sum;
  logic             s2_last;
  logic [PROD_W-1:0] prod;
  res_item_t        push_item;

  logic [OUT_CNT_W-1:0] level;
  logic [OUT_CNT_W-1:0] occupancy;

  // config
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default:          ;
      endcase
    end
  end

  assign fw_ext = WW'(frame_width);
  assign fh_ext = HX'(frame_height);
  assign eff_w  = (fw_ext == '0) ? WW'(1) :
                  (fw_ext > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : fw_ext;
  assign eff_h  = (fh_ext == '0) ? HX'(1) :
                  (fh_ext > HX'(MAX_HEIGHT)) ? HX'(MAX_HEIGHT) : fh_ext;

  // flow control
  assign occupancy = level + OUT_CNT_W'(s1_valid) + OUT_CNT_W'(s2_valid);
  assign pix_stall = (occupancy >= OUT_CNT_W'(OUT_DEPTH));
  assign accept    = pix_valid && !pix_stall;

  // position tracking at accept
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      row_ok[k] = (row >= HX'(k)) && (row < eff_h + HX'(k));
    end
    last0   = (col == '0) && (row == eff_h + HX'(1));
    emit0   = (col == '0) ? row_ok[2] : row_ok[1];
    col_inc = WW'(col) + WW'(1);
    if (last0) begin
      col_next = '0;
      row_next = '0;
    end else if (col_inc >= eff_w) begin
      col_next = '0;
      row_next = (row < eff_h + HX'(1)) ? row + HX'(1) : row;
    end else begin
      col_next = CW'(col_inc);
      row_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cfg_wr) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col   <= col;
      s1_pix   <= pix_data.flush ? '0 : pix_data.pixel;
      s1_ok    <= row_ok;
      s1_czero <= (col == '0);
      s1_cge2  <= (col >= CW'(2));
      s1_wge2  <= (eff_w >= WW'(2));
      s1_rzero <= (row == '0);
      s1_emit  <= emit0;
      s1_last  <= last0;
    end
  end

  bf3m_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (col),
    .wr_en   (s1_valid),
    .wr_addr (s1_col),
    .wr_data (wr_pair),
    .rd_data (rd_pair)
  );

  assign wr_pair.two_above = rd_pair.above;
  assign wr_pair.above     = s1_pix;

  // window and sum; window holds row-masked columns
  always_comb begin
    newcol[0] = s1_ok[2] ? rd_pair.two_above : '0;
    newcol[1] = s1_ok[1] ? rd_pair.above     : '0;
    newcol[2] = s1_ok[0] ? s1_pix            : '0;
    use_w0 = s1_czero ? (s1_wge2 && !s1_rzero) : s1_cge2;
    use_w1 = s1_czero ? !s1_rzero : 1'b1;
    sum1 = '0;
    if (use_w0) begin
      sum1 = sum1 + SUM_W'(col_sum(win0[0], win0[1], win0[2]));
    end
    if (use_w1) begin
      sum1 = sum1 + SUM_W'(col_sum(win1[0], win1[1], win1[2]));
    end
    if (!s1_czero) begin
      sum1 = sum1 + SUM_W'(col_sum(newcol[0], newcol[1], newcol[2]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      for (int k = 0; k < 3; k++) begin
        win0[k] <= '0;
        win1[k] <= '0;
      end
    end else if (s1_valid) begin
      for (int k = 0; k < 3; k++) begin
        win0[k] <= win1[k];
        win1[k] <= newcol[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_sum  <= sum1;
      s2_last <= s1_last;
    end
  end

  // divide by 9
  assign prod = PROD_W'(s2_sum) * PROD_W'(RECIP_9);
  assign push_item.mean_value    = prod[RECIP_SHIFT +: PIX_W];
  assign push_item.last_of_frame = s2_last;

  bf3m_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s2_valid),
    .push_data (push_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .level     (level)
  );

endmodule
`default_nettype wire

>>> tb/box_filter_3x3_mean_unit_test.sv
`default_nettype none
module box_filter_3x3_mean_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bf3m_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 1024;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 150;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int STYLE_CLEAN = 0;
  localparam int STYLE_NOISY = 1;
  localparam int STYLE_FULL  = 2;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pix_valid = 1'b0;
  logic pix_stall;
  pix_item_t pix_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_item_t res_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  pix_item_t pix_q[$];
  res_item_t mean_q[$];

  // filter state mirror
  logic [7:0] above_mem [MAX_W];
  logic [7:0] two_above_mem [MAX_W];
  logic [2:0][7:0] win [2];
  int col_pos = 0;
  int row_pos = 0;
  logic [CFG_W-1:0] width_reg = FRAME_WIDTH_RST;
  logic [CFG_W-1:0] height_reg = FRAME_HEIGHT_RST;

  int errors = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int stall_left = 0;
  bit idling_on = 1'b1;
  int rand_items = 0;

  always #5 clk = ~clk;

  box_filter_3x3_mean_unit i_dut (
    .clk(clk),
    .rst(rst),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .pix_data(pix_data),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data(res_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  function automatic int clamp_dim(logic [CFG_W-1:0] v, int mx);
    if (v == 0) return 1;
    if (v > mx) return mx;
    return v;
  endfunction

  // rows outside the frame contribute zero
  function automatic int col_sum(logic [2:0][7:0] col, int top, int h);
    int s;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      if (top + k >= 0 && top + k < h) s += col[k];
    end
    return s;
  endfunction

  task automatic predict_mean(input pix_item_t it);
    int w, h, c, r, centre, sum;
    logic [7:0] pv;
    logic [2:0][7:0] nc;
    bit is_last;
    res_item_t e;
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, MAX_H);
    c = col_pos;
    r = row_pos;
    pv = it.flush ? 8'd0 : it.pixel;
    if (c >= w) c = 0;
    nc[0] = two_above_mem[c];
    nc[1] = above_mem[c];
    nc[2] = pv;
    sum = 0;
    is_last = 1'b0;
    if (c == 0) begin
      // centre is the last column two rows up
      centre = r - 2;
      if (w >= 2) sum += col_sum(win[0], r - 3, h);
      sum += col_sum(win[1], r - 3, h);
    end else begin
      centre = r - 1;
      if (c >= 2) sum += col_sum(win[0], r - 2, h);
      sum += col_sum(win[1], r - 2, h);
      sum += col_sum(nc, r - 2, h);
    end
    if (centre >= 0 && centre < h) begin
      is_last = (c == 0) && (centre == h - 1);
      e.mean_value = 8'(sum / 9);
      e.last_of_frame = is_last;
      mean_q.push_back(e);
    end
    two_above_mem[c] = above_mem[c];
    above_mem[c] = pv;
    win[0] = win[1];
    win[1] = nc;
    if (is_last) begin
      col_pos = 0;
      row_pos = 0;
    end else begin
      c++;
      if (c >= w) begin
        c = 0;
        if (row_pos < h + 1) row_pos++;
      end
      col_pos = c;
    end
  endtask

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
      send_gap = 0;
    end else if (!pix_valid || !pix_stall) begin
      if (send_gap > 0) begin
        send_gap--;
        pix_valid <= 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 9);
        pix_valid <= 1'b0;
      end else if (pix_q.size() > 0) begin
        pix_valid <= 1'b1;
        pix_data <= pix_q.pop_front();
      end else begin
        pix_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_stall <= 1'b1;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 9);
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    res_item_t e;
    if (!rst) begin
      if (res_valid && !res_stall) begin
        if (mean_q.size() == 0) begin
          flag_error($sformatf("unexpected transaction: mean %0d last %0b",
                               res_data.mean_value, res_data.last_of_frame));
        end else begin
          e = mean_q.pop_front();
          if (res_data.mean_value !== e.mean_value)
            flag_error($sformatf("mean_value mismatch: expected %0d, got %0d",
                                 e.mean_value, res_data.mean_value));
          if (res_data.last_of_frame !== e.last_of_frame)
            flag_error($sformatf("last_of_frame mismatch: expected %0b, got %0b",
                                 e.last_of_frame, res_data.last_of_frame));
        end
      end
      if (pix_valid && !pix_stall) predict_mean(pix_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (pix_valid && !pix_stall) || (res_valid && !res_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("box_filter_3x3_mean_unit_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT) begin
      if (idx == REG_FRAME_WIDTH) width_reg = val;
      else height_reg = val;
      win[0] = '0;
      win[1] = '0;
      col_pos = 0;
      row_pos = 0;
    end
  endtask

  task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input bit spare);
    write_reg(REG_FRAME_WIDTH, w);
    if (spare) write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom));
    write_reg(REG_FRAME_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  // wait for the block to drain: nothing queued, nothing outstanding
  task automatic settle();
    do @(posedge clk); while (pix_q.size() > 0 || pix_valid || mean_q.size() > 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic push_pix(input logic [7:0] p, input logic f);
    pix_item_t it;
    it.pixel = p;
    it.flush = f;
    pix_q.push_back(it);
  endtask

  // one frame plus its drain; cut >= 0 stops after that many transactions
  task automatic queue_frame(input int style, input int cut, output int sent);
    int w, h, n;
    logic [7:0] p;
    logic f;
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, MAX_H);
    n = w * h + w + 1;
    sent = 0;
    for (int i = 0; i < n; i++) begin
      if (cut >= 0 && i >= cut) break;
      p = (style == STYLE_FULL) ? 8'hff : 8'($urandom);
      if (i < w * h) f = (style == STYLE_NOISY) ? ($urandom_range(0, 7) == 0) : 1'b0;
      else f = (style == STYLE_NOISY) ? 1'($urandom_range(0, 1)) : 1'b1;
      push_pix(p, f);
      sent++;
    end
  endtask

  initial begin
    int w, h, nf, pick, style, cut, n, sent;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero sizes act as a single pixel frame
    set_frame(11'd0, 11'd0, 1'b1);
    push_pix(8'hff, 1'b0);
    push_pix(8'h00, 1'b1);
    push_pix(8'h00, 1'b1);
    settle();

    // flush inside the frame, plain pixel during drain
    set_frame(11'd2, 11'd2, 1'b0);
    push_pix(8'hff, 1'b0);
    push_pix(8'hff, 1'b0);
    push_pix(8'hff, 1'b0);
    push_pix(8'hff, 1'b1);
    push_pix(8'hff, 1'b0);
    push_pix(8'h00, 1'b1);
    push_pix(8'h00, 1'b1);
    settle();

    set_frame(11'd3, 11'd3, 1'b0);
    queue_frame(STYLE_FULL, -1, sent);
    settle();

    // register values at full scale; the wide frame stops a few
    // transactions after the row wraps at the widest width
    set_frame(11'd2047, 11'd1, 1'b0);
    queue_frame(STYLE_CLEAN, MAX_W + 6, sent);
    settle();
    set_frame(11'd1, 11'd2047, 1'b0);
    queue_frame(STYLE_NOISY, 40, sent);
    settle();

    while (rand_items < RANDOM_ITEMS) begin
      idling_on = ($urandom_range(0, 4) != 0);
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 8);
      case ($urandom_range(0, 9))
        0: w = 0;
        1: h = 0;
        2: w = $urandom_range(9, 40);
        3: h = $urandom_range(9, 40);
        default: ;
      endcase
      set_frame(CFG_W'(w), CFG_W'(h), $urandom_range(0, 3) == 0);
      nf = $urandom_range(1, 3);
      for (int i = 0; i < nf; i++) begin
        pick = $urandom_range(0, 9);
        style = (pick == 7 || pick == 8) ? STYLE_NOISY :
                (pick == 9) ? STYLE_FULL : STYLE_CLEAN;
        n = clamp_dim(width_reg, MAX_W) * (clamp_dim(height_reg, MAX_H) + 1) + 1;
        cut = (pick == 8) ? $urandom_range(1, n - 1) : -1;
        queue_frame(style, cut, sent);
        rand_items += sent;
        if (cut >= 0) break;
      end
      settle();
    end

    idling_on = 1'b0;
    set_frame(11'd6, 11'd5, 1'b0);
    repeat (2) begin
      queue_frame(STYLE_CLEAN, -1, sent);
    end
    settle();
    repeat (20) @(posedge clk);

    if (errors == 0 && mean_q.size() == 0) begin
      $display("box_filter_3x3_mean_unit_test passed");
    end else begin
      $display("box_filter_3x3_mean_unit_test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
